// ===== rtl/calc_pkg.sv =====
`default_nettype none

package calc_pkg;

  // Field widths on the stream ports.
  localparam int FIELD_W  = 32;
  localparam int KIND_W   = 3;
  localparam int RES_W    = 64;
  localparam int STATUS_W = 2;

  // Operand width taken from each field and the number of fraction bits of the result.
  localparam int OPERAND_BITS = 32;
  localparam int FRAC_BITS    = 16;

  // A power magnitude of 2^ACC_W or more saturates a non-negative exponent result.
  localparam int ACC_W = RES_W - 1 - FRAC_BITS;
  localparam int HI_W  = ACC_W - OPERAND_BITS;
  localparam int PL_W  = 2 * OPERAND_BITS;
  localparam int PH_W  = HI_W + OPERAND_BITS;
  localparam int SUM_W = ACC_W + OPERAND_BITS;

  // Restoring divider: dividend carries the fraction bits, divisor holds either operand or power.
  localparam int DIV_W = OPERAND_BITS + FRAC_BITS;
  localparam int DVS_W = (OPERAND_BITS > FRAC_BITS) ? OPERAND_BITS : FRAC_BITS + 1;
  localparam int CNT_W = $clog2(((DIV_W > ACC_W) ? DIV_W : ACC_W) + 1);

  // Saturation limits of the result.
  localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_ADD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUB = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POW = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    DP_NONE,
    DP_LOAD,
    DP_ADDSUB,
    DP_ERR_DZ,
    DP_ERR_INV,
    DP_MUL,
    DP_MULC,
    DP_DIV_START,
    DP_DIV_STEP,
    DP_DIV_DONE,
    DP_POW_INIT,
    DP_POW_MUL,
    DP_POW_ADD,
    DP_POW_POS,
    DP_POW_ZERO,
    DP_RECIP,
    DP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } calc_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              a_zero;
    logic              b_zero;
    logic              b_neg;
    logic              pow_loop;
    logic              cnt_one;
    logic              sum_big;
    logic              big;
    logic              p_above;
  } calc_st_t;

endpackage

`default_nettype wire

// ===== rtl/calculator_alu_with_power.sv =====
`default_nettype none

// Integer calculator with add, subtract, multiply, divide and integer power on two
// signed 32-bit operands. Each input beat gives one output beat holding the exact
// value as signed fixed point with 16 fraction bits, truncated toward zero and
// saturated at the 64-bit limits, plus a status: division by zero (also a zero base
// with a negative exponent) and unknown codes return zero with a nonzero status.
// One item is in work at a time. Divide produces one quotient bit per cycle over
// 48 bits. Power steps once for each unit of an exponent magnitude k below 47 with
// a base magnitude of at least 2, each step going through the shared multiplier,
// and it stops stepping as soon as the power saturates. A base of 0, 1 or -1, a
// zero exponent and an exponent magnitude of 47 or more skip the stepping. A
// negative exponent runs the reciprocal through the same divider; a power above
// 2^16 skips that division, since its reciprocal truncates to zero. The next item
// is accepted as soon as the result sits in the output register.
module calculator_alu_with_power (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [2*calc_pkg::FIELD_W-1:0]    s_axis_tdata,   // op1, op2
  input  wire  [calc_pkg::KIND_W-1:0]       s_axis_tuser,   // kind
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [calc_pkg::RES_W-1:0]        m_axis_tdata,   // result
  output logic [calc_pkg::STATUS_W-1:0]     m_axis_tuser    // status
);

  calc_pkg::calc_cmd_t cmd;
  calc_pkg::calc_st_t  st;

  // Controller.
  calc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // Datapath.
  calc_dp u_dp (
    .clk_i     (clk_i),
    .in_data_i (s_axis_tdata),
    .in_kind_i (s_axis_tuser),
    .cmd_i     (cmd),
    .res_o     (m_axis_tdata),
    .status_o  (m_axis_tuser),
    .st_o      (st)
  );

endmodule

`default_nettype wire

// ===== rtl/calc_dp.sv =====
`default_nettype none

module calc_dp (
  input  wire                                 clk_i,
  input  wire  [2*calc_pkg::FIELD_W-1:0]      in_data_i,
  input  wire  [calc_pkg::KIND_W-1:0]         in_kind_i,
  input  calc_pkg::calc_cmd_t                 cmd_i,
  output logic [calc_pkg::RES_W-1:0]          res_o,
  output logic [calc_pkg::STATUS_W-1:0]       status_o,
  output calc_pkg::calc_st_t                  st_o
);

  localparam int OB = calc_pkg::OPERAND_BITS;
  localparam int FB = calc_pkg::FRAC_BITS;

  logic [calc_pkg::KIND_W-1:0]   kind_q, kind_d;
  logic [OB-1:0]                 a_q, a_d, b_q, b_d;
  logic [calc_pkg::RES_W-1:0]    acc_q, acc_d;
  logic                          neg_q, neg_d;
  logic                          sat_q, sat_d;
  logic [calc_pkg::STATUS_W-1:0] err_q, err_d;
  logic [calc_pkg::PL_W-1:0]     pl_q, pl_d;
  logic [calc_pkg::PH_W-1:0]     ph_q, ph_d;
  logic [calc_pkg::DIV_W-1:0]    dvd_q, dvd_d;
  logic [calc_pkg::DVS_W-1:0]    rem_q, rem_d, dvs_q, dvs_d;
  logic [calc_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [calc_pkg::RES_W-1:0]    res_q, res_d;
  logic [calc_pkg::STATUS_W-1:0] ost_q, ost_d;

  logic [OB-1:0]                 ma, mb;
  logic                          a_zero, a_one, k_zero, k_big;
  logic signed [OB:0]            add_s;
  logic [OB-1:0]                 mul_x, mul_y;
  logic [calc_pkg::PL_W-1:0]     pl_prod;
  logic [calc_pkg::SUM_W-1:0]    psum;
  logic                          sum_big;
  logic [calc_pkg::DVS_W:0]      rsh, rdiff;

  // Operand magnitudes and flags.
  always_comb begin
    ma     = a_q[OB-1] ? (~a_q + OB'(1)) : a_q;
    mb     = b_q[OB-1] ? (~b_q + OB'(1)) : b_q;
    a_zero = (a_q == '0);
    a_one  = (ma == OB'(1));
    k_zero = (b_q == '0);
    k_big  = (calc_pkg::RES_W'(mb) >= calc_pkg::RES_W'(calc_pkg::ACC_W));
  end

  // Sum or difference of the sign-extended operands.
  always_comb begin
    if (kind_q == calc_pkg::KIND_SUB) begin
      add_s = $signed({a_q[OB-1], a_q}) - $signed({b_q[OB-1], b_q});
    end else begin
      add_s = $signed({a_q[OB-1], a_q}) + $signed({b_q[OB-1], b_q});
    end
  end

  // Shared low multiplier: operand product, or the low part of the power times the base.
  always_comb begin
    mul_x   = (cmd_i.op == calc_pkg::DP_MUL) ? ma : acc_q[OB-1:0];
    mul_y   = (cmd_i.op == calc_pkg::DP_MUL) ? mb : ma;
    pl_prod = calc_pkg::PL_W'(mul_x) * calc_pkg::PL_W'(mul_y);
  end

  // Recombine the partial products of one power step.
  always_comb begin
    psum    = calc_pkg::SUM_W'(pl_q) + (calc_pkg::SUM_W'(ph_q) << OB);
    sum_big = |psum[calc_pkg::SUM_W-1:calc_pkg::ACC_W];
  end

  // One restoring division step.
  always_comb begin
    rsh   = {rem_q, dvd_q[calc_pkg::DIV_W-1]};
    rdiff = rsh - {1'b0, dvs_q};
  end

  // Datapath operations.
  always_comb begin
    kind_d = kind_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    neg_d  = neg_q;
    sat_d  = sat_q;
    err_d  = err_q;
    pl_d   = pl_q;
    ph_d   = ph_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    res_d  = res_q;
    ost_d  = ost_q;
    unique case (cmd_i.op)
      calc_pkg::DP_NONE: begin
      end
      calc_pkg::DP_LOAD: begin
        kind_d = in_kind_i;
        a_d    = in_data_i[OB-1:0];
        b_d    = in_data_i[calc_pkg::FIELD_W+OB-1:calc_pkg::FIELD_W];
        neg_d  = 1'b0;
        sat_d  = 1'b0;
        err_d  = calc_pkg::ST_OK;
        acc_d  = '0;
      end
      calc_pkg::DP_ADDSUB: begin
        acc_d = calc_pkg::RES_W'(add_s) << FB;
        neg_d = 1'b0;
      end
      calc_pkg::DP_ERR_DZ: begin
        err_d = calc_pkg::ST_DIV_ZERO;
      end
      calc_pkg::DP_ERR_INV: begin
        err_d = calc_pkg::ST_INVALID;
      end
      calc_pkg::DP_MUL: begin
        pl_d  = pl_prod;
        neg_d = a_q[OB-1] ^ b_q[OB-1];
      end
      calc_pkg::DP_MULC: begin
        acc_d = calc_pkg::RES_W'(pl_q) << FB;
        sat_d = ((calc_pkg::RES_W'(pl_q) >> calc_pkg::ACC_W) != '0);
      end
      calc_pkg::DP_DIV_START: begin
        dvd_d = calc_pkg::DIV_W'(ma) << FB;
        dvs_d = calc_pkg::DVS_W'(mb);
        rem_d = '0;
        cnt_d = calc_pkg::CNT_W'(calc_pkg::DIV_W);
        neg_d = a_q[OB-1] ^ b_q[OB-1];
      end
      calc_pkg::DP_DIV_STEP: begin
        if (!rdiff[calc_pkg::DVS_W]) begin
          rem_d = rdiff[calc_pkg::DVS_W-1:0];
        end else begin
          rem_d = rsh[calc_pkg::DVS_W-1:0];
        end
        dvd_d = {dvd_q[calc_pkg::DIV_W-2:0], ~rdiff[calc_pkg::DVS_W]};
        cnt_d = cnt_q - calc_pkg::CNT_W'(1);
      end
      calc_pkg::DP_DIV_DONE: begin
        acc_d = calc_pkg::RES_W'(dvd_q);
      end
      calc_pkg::DP_POW_INIT: begin
        neg_d = a_q[OB-1] & mb[0];
        if (a_zero) begin
          acc_d = k_zero ? calc_pkg::RES_W'(1) : '0;
        end else if (a_one || k_zero) begin
          acc_d = calc_pkg::RES_W'(1);
        end else if (k_big) begin
          sat_d = 1'b1;
        end else begin
          acc_d = calc_pkg::RES_W'(1);
          cnt_d = calc_pkg::CNT_W'(mb);
        end
      end
      calc_pkg::DP_POW_MUL: begin
        pl_d = pl_prod;
        ph_d = calc_pkg::PH_W'(acc_q[calc_pkg::ACC_W-1:OB]) * calc_pkg::PH_W'(ma);
      end
      calc_pkg::DP_POW_ADD: begin
        if (sum_big) begin
          sat_d = 1'b1;
        end else begin
          acc_d = calc_pkg::RES_W'(psum[calc_pkg::ACC_W-1:0]);
        end
        cnt_d = cnt_q - calc_pkg::CNT_W'(1);
      end
      calc_pkg::DP_POW_POS: begin
        acc_d = acc_q << FB;
      end
      calc_pkg::DP_POW_ZERO: begin
        acc_d = '0;
        sat_d = 1'b0;
      end
      calc_pkg::DP_RECIP: begin
        dvd_d = calc_pkg::DIV_W'(1) << FB;
        dvs_d = acc_q[calc_pkg::DVS_W-1:0];
        rem_d = '0;
        cnt_d = calc_pkg::CNT_W'(calc_pkg::DIV_W);
      end
      calc_pkg::DP_FIN: begin
        ost_d = err_q;
        if (err_q != calc_pkg::ST_OK) begin
          res_d = '0;
        end else if (sat_q) begin
          res_d = neg_q ? calc_pkg::RES_MIN : calc_pkg::RES_MAX;
        end else begin
          res_d = neg_q ? (~acc_q + calc_pkg::RES_W'(1)) : acc_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Working and output registers.
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    neg_q  <= neg_d;
    sat_q  <= sat_d;
    err_q  <= err_d;
    pl_q   <= pl_d;
    ph_q   <= ph_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
    ost_q  <= ost_d;
  end

  // Status toward the controller.
  always_comb begin
    st_o.kind     = kind_q;
    st_o.a_zero   = a_zero;
    st_o.b_zero   = k_zero;
    st_o.b_neg    = b_q[OB-1];
    st_o.pow_loop = !a_zero && !a_one && !k_zero && !k_big;
    st_o.cnt_one  = (cnt_q == calc_pkg::CNT_W'(1));
    st_o.sum_big  = sum_big;
    st_o.big      = sat_q;
    st_o.p_above  = (acc_q > (calc_pkg::RES_W'(1) << FB));
  end

  assign res_o    = res_q;
  assign status_o = ost_q;

endmodule

`default_nettype wire

// ===== rtl/calc_ctrl.sv =====
`default_nettype none

module calc_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  calc_pkg::calc_st_t   st_i,
  output calc_pkg::calc_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_MULC  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_DIVD  = 4'd4;
  localparam logic [3:0] S_PMUL  = 4'd5;
  localparam logic [3:0] S_PADD  = 4'd6;
  localparam logic [3:0] S_PPOST = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       oval_q, oval_d;
  logic       fin;

  // Sequencing of one item through the datapath.
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = calc_pkg::DP_NONE;
    fin        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = calc_pkg::DP_LOAD;
          state_d  = S_PREP;
        end
      end
      S_PREP: begin
        unique case (st_i.kind)
          calc_pkg::KIND_ADD, calc_pkg::KIND_SUB: begin
            cmd_o.op = calc_pkg::DP_ADDSUB;
            state_d  = S_FIN;
          end
          calc_pkg::KIND_MUL: begin
            cmd_o.op = calc_pkg::DP_MUL;
            state_d  = S_MULC;
          end
          calc_pkg::KIND_DIV: begin
            if (st_i.b_zero) begin
              cmd_o.op = calc_pkg::DP_ERR_DZ;
              state_d  = S_FIN;
            end else begin
              cmd_o.op = calc_pkg::DP_DIV_START;
              state_d  = S_DIV;
            end
          end
          calc_pkg::KIND_POW: begin
            if (st_i.b_neg && st_i.a_zero) begin
              cmd_o.op = calc_pkg::DP_ERR_DZ;
              state_d  = S_FIN;
            end else begin
              cmd_o.op = calc_pkg::DP_POW_INIT;
              state_d  = st_i.pow_loop ? S_PMUL : S_PPOST;
            end
          end
          default: begin
            cmd_o.op = calc_pkg::DP_ERR_INV;
            state_d  = S_FIN;
          end
        endcase
      end
      S_MULC: begin
        cmd_o.op = calc_pkg::DP_MULC;
        state_d  = S_FIN;
      end
      S_DIV: begin
        cmd_o.op = calc_pkg::DP_DIV_STEP;
        if (st_i.cnt_one) begin
          state_d = S_DIVD;
        end
      end
      S_DIVD: begin
        cmd_o.op = calc_pkg::DP_DIV_DONE;
        state_d  = S_FIN;
      end
      S_PMUL: begin
        cmd_o.op = calc_pkg::DP_POW_MUL;
        state_d  = S_PADD;
      end
      S_PADD: begin
        cmd_o.op = calc_pkg::DP_POW_ADD;
        state_d  = (st_i.sum_big || st_i.cnt_one) ? S_PPOST : S_PMUL;
      end
      S_PPOST: begin
        if (!st_i.b_neg) begin
          cmd_o.op = calc_pkg::DP_POW_POS;
          state_d  = S_FIN;
        end else if (st_i.big || st_i.p_above) begin
          cmd_o.op = calc_pkg::DP_POW_ZERO;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = calc_pkg::DP_RECIP;
          state_d  = S_DIV;
        end
      end
      S_FIN: begin
        // Load the output register once the previous beat has left it.
        if (!oval_q || out_ready_i) begin
          cmd_o.op = calc_pkg::DP_FIN;
          fin      = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    if (fin) begin
      oval_d = 1'b1;
    end else if (out_ready_i) begin
      oval_d = 1'b0;
    end else begin
      oval_d = oval_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = oval_q;

endmodule

`default_nettype wire

// ===== tb/calculator_alu_with_power_tb.sv =====
`default_nettype none

module calculator_alu_with_power_tb;

  typedef logic [63:0] u64_t;

  // One expected output beat.
  typedef struct packed {
    logic [calc_pkg::RES_W-1:0]    result;
    logic [calc_pkg::STATUS_W-1:0] status;
  } answer_t;

  // Operation codes the block does not define.
  localparam logic [calc_pkg::KIND_W-1:0] KIND_BAD_ZERO  = 3'd0;
  localparam logic [calc_pkg::KIND_W-1:0] KIND_BAD_SIX   = 3'd6;
  localparam logic [calc_pkg::KIND_W-1:0] KIND_BAD_SEVEN = 3'd7;

  localparam logic [31:0] OP_MAX = 32'h7fff_ffff;
  localparam logic [31:0] OP_MIN = 32'h8000_0000;

  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned RUN_LIMIT    = 1_500_000;

  // Tracks the fixed-point answers still owed by the block and compares each output beat.
  class answer_ledger;
    answer_t     pending_answers[$];
    int unsigned failures;

    function u64_t magnitude(longint v);
      return (v < 0) ? (64'd0 - u64_t'(v)) : u64_t'(v);
    endfunction

    // Product clamped at cap.
    function u64_t capped_mul(u64_t x, u64_t y, u64_t cap);
      u64_t p;
      if (y != 64'd0 && x > cap / y) return cap;
      p = x * y;
      return (p > cap) ? cap : p;
    endfunction

    // Integer power clamped at cap; a base of two or more saturates within 64 steps.
    function u64_t capped_pow(u64_t m, u64_t k, u64_t cap);
      u64_t acc;
      u64_t steps;
      acc = 64'd1;
      if (m <= 64'd1) return (m == 64'd0) ? ((k == 64'd0) ? 64'd1 : 64'd0) : 64'd1;
      steps = (k > 64'd64) ? 64'd64 : k;
      for (u64_t i = 0; i < steps; i++) acc = capped_mul(acc, m, cap);
      return acc;
    endfunction

    // Signed value n/d scaled by the fraction bits, truncated toward zero and saturated.
    function u64_t scale_fixed(bit neg, u64_t n, u64_t d);
      u64_t q;
      u64_t r;
      u64_t lim;
      q = n / d;
      r = n % d;
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      if (q > (64'h8000_0000_0000_0000 >> calc_pkg::FRAC_BITS)) begin
        q = 64'h8000_0000_0000_0000;
      end else begin
        for (int i = 0; i < calc_pkg::FRAC_BITS; i++) begin
          q = q << 1;
          r = r << 1;
          if (r >= d) begin
            r = r - d;
            q[0] = 1'b1;
          end
        end
      end
      if (q > lim) q = lim;
      return neg ? (64'd0 - q) : q;
    endfunction

    function answer_t predict_answer(logic [calc_pkg::KIND_W-1:0] kind, logic [31:0] op1,
                                     logic [31:0] op2);
      answer_t ans;
      longint  a;
      longint  b;
      u64_t    m;
      u64_t    k;
      bit      neg;
      a = longint'($signed(op1[calc_pkg::OPERAND_BITS-1:0]));
      b = longint'($signed(op2[calc_pkg::OPERAND_BITS-1:0]));
      ans.result = '0;
      ans.status = calc_pkg::ST_OK;
      case (kind)
        calc_pkg::KIND_ADD: begin
          ans.result = scale_fixed(a + b < 0, magnitude(a + b), 64'd1);
        end
        calc_pkg::KIND_SUB: begin
          ans.result = scale_fixed(a - b < 0, magnitude(a - b), 64'd1);
        end
        calc_pkg::KIND_MUL: begin
          neg = ((a < 0) != (b < 0)) && a != 0 && b != 0;
          ans.result = scale_fixed(neg, magnitude(a) * magnitude(b), 64'd1);
        end
        calc_pkg::KIND_DIV: begin
          if (b == 0) begin
            ans.status = calc_pkg::ST_DIV_ZERO;
          end else begin
            neg = ((a < 0) != (b < 0)) && a != 0;
            ans.result = scale_fixed(neg, magnitude(a), magnitude(b));
          end
        end
        calc_pkg::KIND_POW: begin
          m = magnitude(a);
          k = magnitude(b);
          neg = (a < 0) && k[0];
          if (b >= 0) begin
            ans.result = scale_fixed(neg, capped_pow(m, k, 64'h8000_0000_0000_0000), 64'd1);
          end else if (m == 64'd0) begin
            // Reciprocal of a zero power.
            ans.status = calc_pkg::ST_DIV_ZERO;
          end else begin
            ans.result = scale_fixed(neg, 64'd1, capped_pow(m, k, 64'd1 << 40));
          end
        end
        default: begin
          ans.status = calc_pkg::ST_INVALID;
        end
      endcase
      if (ans.status != calc_pkg::ST_OK) ans.result = '0;
      return ans;
    endfunction

    function void note_operation(logic [calc_pkg::KIND_W-1:0] kind, logic [31:0] op1,
                                 logic [31:0] op2);
      pending_answers.push_back(predict_answer(kind, op1, op2));
    endfunction

    function void check_answer(logic [calc_pkg::RES_W-1:0] result,
                               logic [calc_pkg::STATUS_W-1:0] status);
      answer_t want;
      if (pending_answers.size() == 0) begin
        $error("unexpected output beat: result %0d status %0d", $signed(result), status);
        failures++;
        return;
      end
      want = pending_answers.pop_front();
      if (result !== want.result) begin
        $error("result: expected %0d, actual %0d", $signed(want.result), $signed(result));
        failures++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        failures++;
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  wire                           s_axis_tready;
  logic [2*calc_pkg::FIELD_W-1:0] s_axis_tdata = '0;   // op1, op2
  logic [calc_pkg::KIND_W-1:0]    s_axis_tuser = '0;   // kind
  wire                           m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  wire  [calc_pkg::RES_W-1:0]     m_axis_tdata;        // result
  wire  [calc_pkg::STATUS_W-1:0]  m_axis_tuser;        // status

  answer_ledger ledger;
  int unsigned  burst_left = 0;
  int unsigned  cycle_count = 0;
  int unsigned  stall_left = 0;
  int unsigned  phase_left = 0;
  bit           choppy = 1'b0;

  calculator_alu_with_power uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("calculator_alu_with_power: mismatch");
      $finish;
    end
  end

  // Receiver: calm stretches with ready held high alternate with choppy stretches of stalls.
  always @(posedge clk_i) begin
    if (phase_left == 0) begin
      choppy <= !choppy;
      phase_left <= $urandom_range(20, 300);
    end else begin
      phase_left <= phase_left - 1;
    end
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (choppy && $urandom_range(0, 2) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Every accepted output beat is checked against the oldest expected answer.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) ledger.check_answer(m_axis_tdata, m_axis_tuser);
  end

  // Present one operation, hold it until accepted, then maybe pause between bursts.
  task automatic send_op(input logic [calc_pkg::KIND_W-1:0] kind, input logic [31:0] op1,
                         input logic [31:0] op2);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {op2, op1};
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.note_operation(kind, op1, op2);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 32) - 16;
      1: begin
        case ($urandom_range(0, 3))
          0: return OP_MAX;
          1: return OP_MIN;
          2: return 32'd0;
          default: return 32'hffff_ffff;
        endcase
      end
      2: return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535) : -$urandom_range(1, 65535);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random_op();
    int unsigned                 pick;
    logic [calc_pkg::KIND_W-1:0] kind;
    logic [31:0]                 op1;
    logic [31:0]                 op2;
    pick = $urandom_range(0, 99);
    if (pick < 14) kind = calc_pkg::KIND_ADD;
    else if (pick < 28) kind = calc_pkg::KIND_SUB;
    else if (pick < 44) kind = calc_pkg::KIND_MUL;
    else if (pick < 64) kind = calc_pkg::KIND_DIV;
    else if (pick < 93) kind = calc_pkg::KIND_POW;
    else if (pick < 95) kind = KIND_BAD_ZERO;
    else if (pick < 97) kind = KIND_BAD_SIX;
    else kind = KIND_BAD_SEVEN;
    op1 = rand_operand();
    op2 = rand_operand();
    if (kind == calc_pkg::KIND_DIV && $urandom_range(0, 9) == 0) op2 = 32'd0;
    // Powers mostly use small bases and small exponents.
    if (kind == calc_pkg::KIND_POW) begin
      case ($urandom_range(0, 4))
        0: ;
        1: op2 = $urandom_range(0, 6) - 3;
        default: begin
          op1 = $urandom_range(0, 24) - 12;
          op2 = $urandom_range(0, 100) - 50;
        end
      endcase
    end
    send_op(kind, op1, op2);
  endtask

  // Reset, directed corners, random operations, then drain and report.
  initial begin
    ledger = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(calc_pkg::KIND_ADD, OP_MAX, OP_MAX);
    send_op(calc_pkg::KIND_ADD, OP_MIN, OP_MIN);
    send_op(calc_pkg::KIND_SUB, OP_MIN, OP_MAX);
    send_op(calc_pkg::KIND_SUB, OP_MAX, OP_MIN);
    send_op(calc_pkg::KIND_MUL, OP_MIN, OP_MIN);
    send_op(calc_pkg::KIND_MUL, OP_MAX, OP_MIN);
    send_op(calc_pkg::KIND_MUL, 32'd0, 32'hffff_fff9);
    send_op(calc_pkg::KIND_DIV, 32'd5, 32'd0);
    send_op(calc_pkg::KIND_DIV, OP_MIN, 32'hffff_ffff);
    send_op(calc_pkg::KIND_DIV, 32'd1, 32'd3);
    send_op(calc_pkg::KIND_DIV, 32'hffff_fff9, 32'd2);
    send_op(calc_pkg::KIND_DIV, 32'd1, OP_MIN);
    send_op(calc_pkg::KIND_POW, 32'd0, 32'd0);
    send_op(calc_pkg::KIND_POW, 32'd0, 32'hffff_ffff);
    send_op(calc_pkg::KIND_POW, 32'd0, 32'd5);
    send_op(calc_pkg::KIND_POW, 32'd2, 32'd46);
    send_op(calc_pkg::KIND_POW, 32'd2, 32'd47);
    send_op(calc_pkg::KIND_POW, 32'hffff_fffe, 32'd47);
    send_op(calc_pkg::KIND_POW, 32'd3, 32'hffff_ffff);
    send_op(calc_pkg::KIND_POW, 32'd2, 32'hffff_ffef);
    send_op(calc_pkg::KIND_POW, 32'hffff_ffff, 32'hffff_fffd);
    send_op(calc_pkg::KIND_POW, OP_MIN, OP_MAX);
    send_op(calc_pkg::KIND_POW, 32'd7, OP_MIN);
    send_op(KIND_BAD_ZERO, OP_MAX, OP_MIN);
    send_op(KIND_BAD_SIX, 32'd1, 32'd1);
    send_op(KIND_BAD_SEVEN, OP_MIN, OP_MAX);

    repeat (RANDOM_ITEMS) send_random_op();
    s_axis_tvalid <= 1'b0;

    while (ledger.pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ledger.failures == 0) begin
      $display("calculator_alu_with_power: match");
    end else begin
      $display("calculator_alu_with_power: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
